// File: src/tbb_pkg.sv
// -----------------------------------------------------------------------------
// tbb_pkg
// Shared types, codes and saturation helper for the transformed box bounds
// block.
// -----------------------------------------------------------------------------
package tbb_pkg;

   typedef logic signed [31:0] q_type;

   // register map, word index
   typedef enum logic [2:0] {
      REG_SHAPE_IS_SPHERE = 3'd0,
      REG_SPHERE_RADIUS   = 3'd1,
      REG_CENTER_X        = 3'd2,
      REG_CENTER_Y        = 3'd3,
      REG_CENTER_Z        = 3'd4,
      REG_EXTENT_X        = 3'd5,
      REG_EXTENT_Y        = 3'd6,
      REG_EXTENT_Z        = 3'd7
   } reg_idx_type;

   localparam logic [1:0] ROW_TRANSLATION = 2'd3;
   localparam int         CSR_ADDR_W      = 5;

   localparam logic signed [47:0] SAT_HI = 48'sh0000_7FFF_FFFF;
   localparam logic signed [47:0] SAT_LO = 48'shFFFF_8000_0000;

   // shape corners per axis, already saturated
   typedef struct packed {
      q_type [2:0] neg;
      q_type [2:0] pos;
      logic        sat;
   } corners_type;

   // one transform: linear rows (entry 3*r+k) and translation
   typedef struct packed {
      q_type [8:0] rows;
      q_type [2:0] trans;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } qstat_type;

   // returns {saturated, value}
   function automatic logic [32:0] sat_q(input logic signed [47:0] v);
      logic [32:0] r;
      if (v > SAT_HI) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < SAT_LO) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

// File: src/tbb_csr.sv
// -----------------------------------------------------------------------------
// tbb_csr
// Shape registers behind the APB port and the registered shape corners.
// -----------------------------------------------------------------------------
module tbb_csr
   import tbb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output corners_type           corners
);

   logic              sphere_ff;
   logic [30:0]       radius_ff;
   q_type [2:0]       center_ff;
   logic [2:0][30:0]  extent_ff;
   corners_type       corners_ff, corners_in;
   logic              wr_en;
   reg_idx_type       idx;

   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign idx   = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sphere_ff  <= 1'b0;
         radius_ff  <= '0;
         center_ff  <= '0;
         extent_ff  <= '0;
         corners_ff <= '0;
      end else begin
         corners_ff <= corners_in;
         if (wr_en) begin
            unique case (idx)
               REG_SHAPE_IS_SPHERE: sphere_ff    <= csr_pwdata[0];
               REG_SPHERE_RADIUS:   radius_ff    <= csr_pwdata[30:0];
               REG_CENTER_X:        center_ff[0] <= csr_pwdata;
               REG_CENTER_Y:        center_ff[1] <= csr_pwdata;
               REG_CENTER_Z:        center_ff[2] <= csr_pwdata;
               REG_EXTENT_X:        extent_ff[0] <= csr_pwdata[30:0];
               REG_EXTENT_Y:        extent_ff[1] <= csr_pwdata[30:0];
               REG_EXTENT_Z:        extent_ff[2] <= csr_pwdata[30:0];
            endcase
         end
      end
   end

   always_comb begin
      unique case (idx)
         REG_SHAPE_IS_SPHERE: csr_prdata = {31'b0, sphere_ff};
         REG_SPHERE_RADIUS:   csr_prdata = {1'b0, radius_ff};
         REG_CENTER_X:        csr_prdata = center_ff[0];
         REG_CENTER_Y:        csr_prdata = center_ff[1];
         REG_CENTER_Z:        csr_prdata = center_ff[2];
         REG_EXTENT_X:        csr_prdata = {1'b0, extent_ff[0]};
         REG_EXTENT_Y:        csr_prdata = {1'b0, extent_ff[1]};
         REG_EXTENT_Z:        csr_prdata = {1'b0, extent_ff[2]};
      endcase
   end

   // center +/- half extent, a sphere uses its radius on all axes
   always_comb begin
      logic [30:0]        half;
      logic signed [47:0] c48, h48;
      logic [32:0]        p, n;
      corners_in = '0;
      for (int k = 0; k < 3; k++) begin
         half = sphere_ff ? radius_ff : extent_ff[k];
         c48  = {{16{center_ff[k][31]}}, center_ff[k]};
         h48  = {17'b0, half};
         p    = sat_q(c48 + h48);
         n    = sat_q(c48 - h48);
         corners_in.pos[k] = p[31:0];
         corners_in.neg[k] = n[31:0];
         corners_in.sat    = corners_in.sat | p[32] | n[32];
      end
   end

   assign corners = corners_ff;

endmodule

// File: src/tbb_front.sv
// -----------------------------------------------------------------------------
// tbb_front
// Takes matrix row words, keeps the linear rows, queues a transform job on
// every translation row.
// -----------------------------------------------------------------------------
module tbb_front
   import tbb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_row_index,
   input  logic [31:0] req_col_a,
   input  logic [31:0] req_col_b,
   input  logic [31:0] req_col_c,
   input  qstat_type   qstat,
   output push_type    push
);

   q_type [8:0] rows_ff, rows_in;
   q_type [2:0] cols;
   logic        accept;

   assign cols      = {req_col_c, req_col_b, req_col_a};
   assign req_stall = qstat.full;
   assign accept    = req_valid & ~qstat.full;

   always_comb begin
      rows_in = rows_ff;
      if (accept && req_row_index != ROW_TRANSLATION) begin
         for (int r = 0; r < 3; r++) begin
            if (req_row_index == 2'(r)) begin
               for (int k = 0; k < 3; k++) begin
                  rows_in[3*r+k] = cols[k];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
      end else begin
         rows_ff <= rows_in;
      end
   end

   assign push.valid     = accept & (req_row_index == ROW_TRANSLATION);
   assign push.job.rows  = rows_ff;
   assign push.job.trans = cols;

endmodule

// File: src/tbb_queue.sv
// -----------------------------------------------------------------------------
// tbb_queue
// Short job queue between front and back end.
// -----------------------------------------------------------------------------
module tbb_queue
   import tbb_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop,
   output qstat_type qstat,
   output job_type   head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign qstat.full       = (count_ff == CNT_W'(DEPTH));
   assign qstat.head_valid = (count_ff != '0);
   assign do_push          = push.valid & ~qstat.full;
   assign do_pop           = pop & qstat.head_valid;
   assign head             = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

// File: src/tbb_back.sv
// -----------------------------------------------------------------------------
// tbb_back
// Four-stage transform pipe: products, floor/saturate, per-term min/max,
// sums into the result register.
// -----------------------------------------------------------------------------
module tbb_back
   import tbb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  qstat_type   qstat,
   input  job_type     head,
   input  corners_type corners,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_low_x,
   output logic [31:0] rsp_low_y,
   output logic [31:0] rsp_low_z,
   output logic [31:0] rsp_high_x,
   output logic [31:0] rsp_high_y,
   output logic [31:0] rsp_high_z,
   output logic        rsp_overflowed
);

   // Each world axis is a sum of one term per local axis, and each term has
   // only two choices (neg or pos corner), so the corner min/max splits into
   // a per-term min/max. Saturation is monotone, so it commutes with that.

   logic adv;

   // stage 1: products [j local axis][k world axis][b corner side]
   logic               v1_ff;
   logic signed [63:0] prod_ff [3][3][2];
   logic signed [63:0] prod_in [3][3][2];
   q_type [2:0]        t1_ff;
   logic               f1_ff;

   // stage 2: floored, saturated products
   logic               v2_ff;
   q_type              ps_ff [3][3][2];
   q_type              ps_in [3][3][2];
   q_type [2:0]        t2_ff;
   logic               f2_ff, f2_in;

   // stage 3: per-term min and max
   logic               v3_ff;
   q_type              mn_ff [3][3];
   q_type              mx_ff [3][3];
   q_type              mn_in [3][3];
   q_type              mx_in [3][3];
   q_type [2:0]        t3_ff;
   logic               f3_ff;

   // stage 4: result word
   logic               out_v_ff;
   q_type [2:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic               of_ff, of_in;

   assign adv = ~out_v_ff | ~rsp_stall;
   assign pop = adv & qstat.head_valid;

   always_comb begin
      logic signed [31:0] a, m;
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            for (int b = 0; b < 2; b++) begin
               a = (b == 1) ? corners.pos[j] : corners.neg[j];
               m = head.rows[3*j+k];
               prod_in[j][k][b] = a * m;
            end
         end
      end
   end

   always_comb begin
      logic [32:0] s;
      f2_in = f1_ff;
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            for (int b = 0; b < 2; b++) begin
               // arithmetic shift by 16 is the floor
               s = sat_q(prod_ff[j][k][b][63:16]);
               ps_in[j][k][b] = s[31:0];
               f2_in = f2_in | s[32];
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            if ($signed(ps_ff[j][k][0]) < $signed(ps_ff[j][k][1])) begin
               mn_in[j][k] = ps_ff[j][k][0];
               mx_in[j][k] = ps_ff[j][k][1];
            end else begin
               mn_in[j][k] = ps_ff[j][k][1];
               mx_in[j][k] = ps_ff[j][k][0];
            end
         end
      end
   end

   always_comb begin
      logic signed [33:0] sl, sh;
      logic [32:0]        rl, rh;
      of_in = f3_ff;
      lo_in = '0;
      hi_in = '0;
      for (int k = 0; k < 3; k++) begin
         sl = {{2{t3_ff[k][31]}}, t3_ff[k]};
         sh = sl;
         for (int j = 0; j < 3; j++) begin
            sl = sl + {{2{mn_ff[j][k][31]}}, mn_ff[j][k]};
            sh = sh + {{2{mx_ff[j][k][31]}}, mx_ff[j][k]};
         end
         rl = sat_q({{14{sl[33]}}, sl});
         rh = sat_q({{14{sh[33]}}, sh});
         lo_in[k] = rl[31:0];
         hi_in[k] = rh[31:0];
         of_in = of_in | rl[32] | rh[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= qstat.head_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         out_v_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         t1_ff   <= head.trans;
         f1_ff   <= corners.sat;
         ps_ff   <= ps_in;
         t2_ff   <= t1_ff;
         f2_ff   <= f2_in;
         mn_ff   <= mn_in;
         mx_ff   <= mx_in;
         t3_ff   <= t2_ff;
         f3_ff   <= f2_ff;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         of_ff   <= of_in;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_low_x      = lo_ff[0];
   assign rsp_low_y      = lo_ff[1];
   assign rsp_low_z      = lo_ff[2];
   assign rsp_high_x     = hi_ff[0];
   assign rsp_high_y     = hi_ff[1];
   assign rsp_high_z     = hi_ff[2];
   assign rsp_overflowed = of_ff;

endmodule

// File: src/transformed_box_bounds.sv
// -----------------------------------------------------------------------------
// transformed_box_bounds
// World axis-aligned bounds of a box or sphere shape under a 4x3 affine
// matrix streamed one row per word, signed Q16.16 with saturation.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   row_index, col_a, col_b, col_c
//   rsp      out  rsp_valid/rsp_stall   low_x/y/z, high_x/y/z, overflowed
//   csr      in   APB, pready tied high 8 registers at byte address 4*i
//
// One word accepted per cycle while req_stall is low; rows 0..2 only update
// the stored matrix. A translation word passes through the queue and the four
// back-end stages (multiply, floor/saturate, min/max, sum) to its result.
// Sustained rate is one translation per cycle with no stall on rsp.
// rsp_stall freezes the whole back end; the queue then fills and raises
// req_stall. Synchronous reset clears the registers, matrix rows and queue.
// -----------------------------------------------------------------------------
module transformed_box_bounds
   import tbb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_row_index,
   input  logic [31:0]           req_col_a,
   input  logic [31:0]           req_col_b,
   input  logic [31:0]           req_col_c,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_low_x,
   output logic [31:0]           rsp_low_y,
   output logic [31:0]           rsp_low_z,
   output logic [31:0]           rsp_high_x,
   output logic [31:0]           rsp_high_y,
   output logic [31:0]           rsp_high_z,
   output logic                  rsp_overflowed,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   corners_type corners;
   push_type    push;
   qstat_type   qstat;
   job_type     head;
   logic        pop;

   assign csr_pready = 1'b1;

   tbb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .corners     (corners)
   );

   tbb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_row_index (req_row_index),
      .req_col_a     (req_col_a),
      .req_col_b     (req_col_b),
      .req_col_c     (req_col_c),
      .qstat         (qstat),
      .push          (push)
   );

   tbb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .qstat (qstat),
      .head  (head)
   );

   tbb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .qstat          (qstat),
      .head           (head),
      .corners        (corners),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_low_x      (rsp_low_x),
      .rsp_low_y      (rsp_low_y),
      .rsp_low_z      (rsp_low_z),
      .rsp_high_x     (rsp_high_x),
      .rsp_high_y     (rsp_high_y),
      .rsp_high_z     (rsp_high_z),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule

// File: src/tbb_checker.sv
// -----------------------------------------------------------------------------
// tbb_checker
// Port-level checks for transformed_box_bounds, bound to the top level.
// -----------------------------------------------------------------------------
module tbb_checker
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_low_x,
   input logic [31:0] rsp_low_y,
   input logic [31:0] rsp_low_z,
   input logic [31:0] rsp_high_x,
   input logic [31:0] rsp_high_y,
   input logic [31:0] rsp_high_z,
   input logic        rsp_overflowed
);

   // a stalled result word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // and keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_low_x) && $stable(rsp_low_y)
         && $stable(rsp_low_z) && $stable(rsp_high_x) && $stable(rsp_high_y)
         && $stable(rsp_high_z) && $stable(rsp_overflowed))
      else $error("rsp payload changed while stalled");

   // bounds are ordered on every axis
   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_low_x) <= $signed(rsp_high_x)
         && $signed(rsp_low_y) <= $signed(rsp_high_y)
         && $signed(rsp_low_z) <= $signed(rsp_high_z))
      else $error("low bound above high bound");

   // reset empties the pipe and the queue
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipe not empty after reset");

endmodule

bind transformed_box_bounds tbb_checker u_tbb_checker (.*);
